// ----- hdl/rsi_pkg.sv -----
`default_nettype none

package rsi_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int XW         = 32;
  localparam int W2         = 2 * XW;
  localparam int DSW        = W2 + 1;
  localparam int SUM_W      = W2 + 2;
  localparam int DISC_W     = W2 - 1;
  localparam int ROOT_W     = 32;
  localparam int Q_W        = 35;
  localparam int DEN_W      = 34;
  localparam int NUM_W      = DEN_W + FRAC_BITS;
  localparam int QUO_W      = XW;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int BACK_LAT   = ROOT_W + 1 + DIV_LAT + 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CFG_AW     = 4;

  typedef logic signed [XW-1:0] fx_t;
  typedef logic [2:0][XW-1:0] vec3_t;

  localparam fx_t FX_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(XW-1){1'b0}}};

  // quadratic terms of one ray, handed from front to back
  typedef struct packed {
    logic              nohit;
    logic [DISC_W-1:0] disc;
    fx_t               h;
    fx_t               a;
    fx_t               c;
    vec3_t             org;
    vec3_t             dir;
  } quad_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // clamp a wide signed value into the fixed-point range
  function automatic fx_t sat_fx(input logic signed [SUM_W-1:0] v);
    fx_t r;
    if (v[SUM_W-1:XW-1] == '0 || v[SUM_W-1:XW-1] == '1) begin
      r = v[XW-1:0];
    end else begin
      r = v[SUM_W-1] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rsi_front.sv -----
`default_nettype none

module rsi_front import rsi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vec3_t           in_org,
  input  vec3_t           in_dir,
  input  logic [XW-2:0]   radius,
  input  vec3_t           center,
  input  logic            q_full,
  output logic            push,
  output quad_t           push_data
);

  logic en;
  logic v0_r, v1_r, v2_r, v3_r;
  vec3_t org0_r, dir0_r, rel0_r;
  vec3_t org1_r, dir1_r, org2_r, dir2_r, org3_r, dir3_r;
  logic signed [W2-1:0] dd_r [3];
  logic signed [W2-1:0] rd_r [3];
  logic signed [W2-1:0] rr_r [3];
  logic [W2-3:0] radsq_r;
  fx_t a2_r, h2_r, c2_r, a3_r, h3_r, c3_r;
  logic signed [W2-1:0] hh_r, ac_r;
  vec3_t rel_nxt;
  fx_t a_nxt, h_nxt, c_nxt;
  logic signed [DSW-1:0] disc;

  assign en       = !v3_r || !q_full;
  assign in_ready = en;
  assign push     = v3_r && !q_full;

  // origin relative to sphere centre
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rel_nxt[i] = sat_fx(SUM_W'($signed(in_org[i])) - SUM_W'($signed(center[i])));
    end
  end

  // floor-shifted dot products
  always_comb begin
    logic signed [SUM_W-1:0] sa, sh, sc;
    sa = '0;
    sh = '0;
    sc = '0;
    for (int i = 0; i < 3; i++) begin
      sa = sa + SUM_W'(dd_r[i] >>> FRAC_BITS);
      sh = sh + SUM_W'(rd_r[i] >>> FRAC_BITS);
      sc = sc + SUM_W'(rr_r[i] >>> FRAC_BITS);
    end
    sc = sc - SUM_W'($signed({1'b0, radsq_r >> FRAC_BITS}));
    a_nxt = sat_fx(sa);
    h_nxt = sat_fx(sh);
    c_nxt = sat_fx(sc);
  end

  assign disc = DSW'(hh_r) - DSW'(ac_r);

  always_comb begin
    push_data.nohit = (a3_r == '0) || disc[DSW-1];
    push_data.disc  = disc[DISC_W-1:0];
    push_data.h     = h3_r;
    push_data.a     = a3_r;
    push_data.c     = c3_r;
    push_data.org   = org3_r;
    push_data.dir   = dir3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      org0_r <= in_org;
      dir0_r <= in_dir;
      rel0_r <= rel_nxt;
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= $signed(dir0_r[i]) * $signed(dir0_r[i]);
        rd_r[i] <= $signed(rel0_r[i]) * $signed(dir0_r[i]);
        rr_r[i] <= $signed(rel0_r[i]) * $signed(rel0_r[i]);
      end
      radsq_r <= radius * radius;
      org1_r  <= org0_r;
      dir1_r  <= dir0_r;
      a2_r    <= a_nxt;
      h2_r    <= h_nxt;
      c2_r    <= c_nxt;
      org2_r  <= org1_r;
      dir2_r  <= dir1_r;
      hh_r    <= h2_r * h2_r;
      ac_r    <= a2_r * c2_r;
      a3_r    <= a2_r;
      h3_r    <= h2_r;
      c3_r    <= c2_r;
      org3_r  <= org2_r;
      dir3_r  <= dir2_r;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rsi_fifo.sv -----
`default_nettype none

module rsi_fifo import rsi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  quad_t  wdata,
  input  logic   pop,
  output quad_t  rdata,
  output qstat_t stat
);

  quad_t mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0] cnt_r;

  assign stat.full  = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a write");

endmodule

`default_nettype wire

// ----- hdl/rsi_div.sv -----
`default_nettype none

module rsi_div import rsi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             neg,
  output fx_t              quo
);

  localparam int REM_W = DEN_W + 1;
  localparam logic [QUO_W-1:0] MAG_POS = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] MAG_NEG = {1'b1, {(QUO_W-1){1'b0}}};

  logic [REM_W-1:0] rem_r [DIV_LAT];
  logic [QUO_W-1:0] low_r [DIV_LAT];
  logic [QUO_W-1:0] quo_r [DIV_LAT];
  logic [DEN_W-1:0] den_r [DIV_LAT];
  logic             ovf_r [DIV_LAT];
  logic             neg_r [DIV_LAT];
  logic [QUO_W-1:0] mag;
  logic [QUO_W:0]   negm;

  // quotient of 2^32 or more is flagged up front, then one bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(num[NUM_W-1:QUO_W]);
      low_r[0] <= num[QUO_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      ovf_r[0] <= REM_W'(num[NUM_W-1:QUO_W]) >= REM_W'(den);
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
    logic [REM_W-1:0] trial;
    assign trial = {rem_r[j-1][REM_W-2:0], low_r[j-1][QUO_W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= REM_W'(den_r[j-1])) begin
          rem_r[j] <= trial - REM_W'(den_r[j-1]);
          quo_r[j] <= {quo_r[j-1][QUO_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= trial;
          quo_r[j] <= {quo_r[j-1][QUO_W-2:0], 1'b0};
        end
        low_r[j] <= {low_r[j-1][QUO_W-2:0], 1'b0};
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign mag  = quo_r[DIV_LAT-1];
  assign negm = -{1'b0, mag};

  always_comb begin
    if (ovf_r[DIV_LAT-1]) begin
      quo = neg_r[DIV_LAT-1] ? FX_MIN : FX_MAX;
    end else if (neg_r[DIV_LAT-1]) begin
      quo = (mag > MAG_NEG) ? FX_MIN : negm[QUO_W-1:0];
    end else begin
      quo = (mag > MAG_POS) ? FX_MAX : mag;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rsi_back.sv -----
`default_nettype none

module rsi_back import rsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  quad_t      q_data,
  input  qstat_t     q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_root_count,
  output fx_t        out_t_near,
  output fx_t        out_t_far,
  output vec3_t      out_near,
  output vec3_t      out_far
);

  localparam logic [1:0] RC_NONE = 2'd0;
  localparam logic [1:0] RC_ONE  = 2'd1;
  localparam logic [1:0] RC_TWO  = 2'd2;
  localparam int SQ_W = DISC_W + 2;

  typedef struct packed {
    logic  nohit;
    fx_t   h;
    fx_t   a;
    fx_t   c;
    vec3_t org;
    vec3_t dir;
  } sq_pay_t;

  typedef struct packed {
    logic  nohit;
    logic  qzero;
    vec3_t org;
    vec3_t dir;
  } tag_t;

  logic en;
  logic [BACK_LAT-1:0] vld_r;

  logic [DISC_W-1:0] rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  sq_pay_t           spay_r  [ROOT_W];

  logic signed [Q_W-1:0] q_r, s_ext, h_ext, q_nxt;
  sq_pay_t qpay_r;
  logic [Q_W-1:0] qmag;
  logic signed [XW:0] c_ext;
  logic [XW:0] cmag;
  logic [NUM_W-1:0] num1, num2;
  logic [DEN_W-1:0] den1, den2;
  logic neg1, neg2;
  fx_t t1, t2, t2s;
  tag_t tag_r [DIV_LAT];

  fx_t tn1_r, tf1_r, tn2_r, tf2_r;
  logic [1:0] rc1_r, rc2_r;
  logic nohit1_r, nohit2_r;
  vec3_t org1_r, dir1_r, org2_r;
  logic signed [W2-1:0] pn_r [3];
  logic signed [W2-1:0] pf_r [3];

  assign en        = !vld_r[BACK_LAT-1] || out_ready;
  assign pop       = en && !q_stat.empty;
  assign out_valid = vld_r[BACK_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_LAT-2:0], pop};
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [DISC_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    sq_pay_t           pay_in;
    logic [SQ_W-1:0]   trial;
    if (j == 0) begin : g_first
      always_comb begin
        rem_in       = q_data.disc;
        root_in      = '0;
        pay_in.nohit = q_data.nohit;
        pay_in.h     = q_data.h;
        pay_in.a     = q_data.a;
        pay_in.c     = q_data.c;
        pay_in.org   = q_data.org;
        pay_in.dir   = q_data.dir;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem_r[j-1];
        root_in = root_r[j-1];
        pay_in  = spay_r[j-1];
      end
    end
    assign trial = (SQ_W'(root_in) << (K + 1)) | (SQ_W'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if (SQ_W'(rem_in) >= trial) begin
          rem_r[j]  <= rem_in - trial[DISC_W-1:0];
          root_r[j] <= root_in | (ROOT_W'(1) << K);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
        spay_r[j] <= pay_in;
      end
    end
  end

  // stable root form of q
  always_comb begin
    s_ext = $signed({{(Q_W-ROOT_W){1'b0}}, root_r[ROOT_W-1]});
    h_ext = Q_W'(spay_r[ROOT_W-1].h);
    q_nxt = h_ext[Q_W-1] ? (s_ext - h_ext) : -(h_ext + s_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      qpay_r <= spay_r[ROOT_W-1];
    end
  end

  // sign and magnitude for the two dividers
  always_comb begin
    qmag  = q_r[Q_W-1] ? -q_r : q_r;
    c_ext = (XW+1)'(qpay_r.c);
    cmag  = c_ext[XW] ? -c_ext : c_ext;
    num1  = {qmag[DEN_W-1:0], {FRAC_BITS{1'b0}}};
    den1  = {{(DEN_W-XW){1'b0}}, qpay_r.a};
    neg1  = q_r[Q_W-1];
    num2  = {{(DEN_W-XW-1){1'b0}}, cmag, {FRAC_BITS{1'b0}}};
    den2  = qmag[DEN_W-1:0];
    neg2  = qpay_r.c[XW-1] ^ q_r[Q_W-1];
  end

  rsi_div u_div_t1 (
    .clk (clk),
    .en  (en),
    .num (num1),
    .den (den1),
    .neg (neg1),
    .quo (t1)
  );

  rsi_div u_div_t2 (
    .clk (clk),
    .en  (en),
    .num (num2),
    .den (den2),
    .neg (neg2),
    .quo (t2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0].nohit <= qpay_r.nohit;
      tag_r[0].qzero <= (q_r == '0);
      tag_r[0].org   <= qpay_r.org;
      tag_r[0].dir   <= qpay_r.dir;
      for (int j = 1; j < DIV_LAT; j++) begin
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  // zero q gives both roots at the origin
  assign t2s = tag_r[DIV_LAT-1].qzero ? '0 : t2;

  always_ff @(posedge clk) begin
    if (en) begin
      tn1_r    <= (t1 > t2s) ? t2s : t1;
      tf1_r    <= (t1 > t2s) ? t1 : t2s;
      rc1_r    <= tag_r[DIV_LAT-1].nohit ? RC_NONE : ((t1 == t2s) ? RC_ONE : RC_TWO);
      nohit1_r <= tag_r[DIV_LAT-1].nohit;
      org1_r   <= tag_r[DIV_LAT-1].org;
      dir1_r   <= tag_r[DIV_LAT-1].dir;
      for (int i = 0; i < 3; i++) begin
        pn_r[i] <= tn1_r * $signed(dir1_r[i]);
        pf_r[i] <= tf1_r * $signed(dir1_r[i]);
      end
      tn2_r    <= tn1_r;
      tf2_r    <= tf1_r;
      rc2_r    <= rc1_r;
      nohit2_r <= nohit1_r;
      org2_r   <= org1_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_root_count <= rc2_r;
      out_t_near     <= nohit2_r ? '0 : tn2_r;
      out_t_far      <= nohit2_r ? '0 : tf2_r;
      for (int i = 0; i < 3; i++) begin
        out_near[i] <= nohit2_r ? '0 :
          sat_fx(SUM_W'(pn_r[i] >>> FRAC_BITS) + SUM_W'($signed(org2_r[i])));
        out_far[i]  <= nohit2_r ? '0 :
          sat_fx(SUM_W'(pf_r[i] >>> FRAC_BITS) + SUM_W'($signed(org2_r[i])));
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ray_sphere_intersect.sv -----
// channel  | direction | handshake                  | content
// ---------+-----------+----------------------------+-------------------------------------
// in_      | input     | in_valid / in_ready        | ray origin and direction, Q16.16
// out_     | output    | out_valid / out_ready      | root count, t_near/t_far, hit points
// config   | input     | psel/penable/pwrite, pready| radius, centre x/y/z
//
// one ray per clock sustained while out_ready stays high; the back pipeline holds the
// 32-stage square root and the 33-stage dividers
// synchronous active-low reset clears the pipeline valids and the queue,
// radius resets to 1.0 and the centre to the origin
// out_ready low while out_valid is high freezes the back pipeline; the 4-entry queue lets the front
// keep taking rays until it fills, then in_ready drops
`default_nettype none

module ray_sphere_intersect import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [XW-1:0]     pwdata,
  output logic [XW-1:0]     prdata,
  output logic              pready,
  // ray input
  input  logic              in_valid,
  output logic              in_ready,
  input  fx_t               in_origin_x,
  input  fx_t               in_origin_y,
  input  fx_t               in_origin_z,
  input  fx_t               in_dir_x,
  input  fx_t               in_dir_y,
  input  fx_t               in_dir_z,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_root_count,
  output fx_t               out_t_near,
  output fx_t               out_t_far,
  output fx_t               out_near_x,
  output fx_t               out_near_y,
  output fx_t               out_near_z,
  output fx_t               out_far_x,
  output fx_t               out_far_y,
  output fx_t               out_far_z
);

  // register map, one word every four byte addresses, indexed by paddr[3:2]
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_CX     = 2'd1;
  localparam logic [1:0] REG_CY     = 2'd2;
  localparam logic [1:0] REG_CZ     = 2'd3;

  logic [XW-2:0] radius_r;
  vec3_t center_r;
  logic wr_en;
  logic [1:0] reg_idx;

  vec3_t in_org, in_dir;
  logic push, pop;
  quad_t push_data, pop_data;
  qstat_t q_stat;
  vec3_t near_pt, far_pt;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // configuration writes complete in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= (XW-1)'(1) << FRAC_BITS;
      center_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS: radius_r    <= pwdata[XW-2:0];
        REG_CX:     center_r[0] <= pwdata;
        REG_CY:     center_r[1] <= pwdata;
        REG_CZ:     center_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = {1'b0, radius_r};
      REG_CX:     prdata = center_r[0];
      REG_CY:     prdata = center_r[1];
      REG_CZ:     prdata = center_r[2];
      default:    prdata = '0;
    endcase
  end

  assign in_org = {in_origin_z, in_origin_y, in_origin_x};
  assign in_dir = {in_dir_z, in_dir_y, in_dir_x};

  // front: relative origin, a/h/c and discriminant, hit classification
  rsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_org    (in_org),
    .in_dir    (in_dir),
    .radius    (radius_r),
    .center    (center_r),
    .q_full    (q_stat.full),
    .push      (push),
    .push_data (push_data)
  );

  // short queue decouples the two pipelines
  rsi_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (pop_data),
    .stat  (q_stat)
  );

  // back: square root, q, two divisions, ordering, hit points
  rsi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (pop_data),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root_count (out_root_count),
    .out_t_near     (out_t_near),
    .out_t_far      (out_t_far),
    .out_near       (near_pt),
    .out_far        (far_pt)
  );

  assign out_near_x = near_pt[0];
  assign out_near_y = near_pt[1];
  assign out_near_z = near_pt[2];
  assign out_far_x  = far_pt[0];
  assign out_far_y  = far_pt[1];
  assign out_far_z  = far_pt[2];

endmodule

`default_nettype wire
